// File: sv/lbc_pkg.sv
package lbc_pkg;

  // Field widths fixed by the interface
  localparam int BLK_W           = 32;
  localparam int SLOT_W          = 4;
  localparam int NUM_BUFFERS_DEF = 16;

  // Operation codes carried on in_op
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_HIT      = 2'd0,
    STATUS_MISS     = 2'd1,
    STATUS_DEADLOCK = 2'd2,
    STATUS_RELEASED = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } lbc_state_t;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

  // Status from the scan unit back to the sequencer
  typedef struct packed {
    logic hit;
    logic victim;
  } scan_flags_t;

endpackage

// File: sv/lru_block_buffer_cache_top.sv
// Channel   Ports                                            Handshake
// input     in_op in_block_number in_slot in_modified        start && !busy
// result    out_status out_slot_out out_fetch_block          out_valid, one cycle
//           out_writeback_needed out_writeback_block
//
// An acquire walks the tag RAM one entry a cycle through a shared compare
// unit, then passes the drain and finish states; the result is registered at finish.
// A release updates the flags at once; its result appears in the next cycle.
// Synchronous active-low reset empties the directory; no clearing pass needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_block_buffer_cache_top import lbc_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_op,
  input  logic [BLK_W-1:0]  in_block_number,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_modified,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic [BLK_W-1:0]  out_fetch_block,
  output logic              out_writeback_needed,
  output logic [BLK_W-1:0]  out_writeback_block
);

  localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  lbc_state_t state_r;
  lbc_state_t state_nxt;

  logic [IDX_W-1:0] idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [BLK_W-1:0] key_r;

  logic [NUM_BUFFERS-1:0] valid_r;
  logic [NUM_BUFFERS-1:0] pinned_r;
  logic [NUM_BUFFERS-1:0] dirty_r;
  logic [IDX_W-1:0]       rank_r [NUM_BUFFERS];

  logic              out_valid_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [BLK_W-1:0]  out_fetch_r;
  logic              out_wb_needed_r;
  logic [BLK_W-1:0]  out_wb_block_r;

  logic        accept;
  logic        ram_rd_en;
  logic        fin_en;
  scan_ctrl_t  scan_ctrl;
  scan_flags_t scan_flags;

  logic [BLK_W-1:0] tag_rd;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic [IDX_W-1:0] vict_idx;
  logic [IDX_W-1:0] vict_rank;
  logic [BLK_W-1:0] vict_tag;

  logic             fin_hit;
  logic             fin_miss;
  logic             fin_apply;
  logic [IDX_W-1:0] fin_slot;
  logic [IDX_W-1:0] fin_rank;
  logic             fin_wb;
  logic             rel_en;
  logic             rel_ok;
  logic [IDX_W-1:0] rel_idx;

  // Tag storage
  lbc_tag_ram #(
    .DEPTH  (NUM_BUFFERS),
    .ADDR_W (IDX_W)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (fin_en && fin_miss),
    .wr_addr (vict_idx),
    .wr_data (key_r),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (tag_rd)
  );

  // Shared compare unit
  lbc_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (scan_ctrl),
    .ent_idx    (cmp_idx_r),
    .ent_valid  (valid_r[cmp_idx_r]),
    .ent_pinned (pinned_r[cmp_idx_r]),
    .ent_rank   (rank_r[cmp_idx_r]),
    .ent_tag    (tag_rd),
    .key        (key_r),
    .flags      (scan_flags),
    .hit_idx    (hit_idx),
    .hit_rank   (hit_rank),
    .vict_idx   (vict_idx),
    .vict_rank  (vict_rank),
    .vict_tag   (vict_tag)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_op == OP_ACQUIRE)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy            = 1'b1;
    ram_rd_en       = 1'b0;
    fin_en          = 1'b0;
    case (state_r)
      ST_IDLE:   busy      = 1'b0;
      ST_SCAN:   ram_rd_en = 1'b1;
      ST_DRAIN:  busy      = 1'b1;
      ST_FINISH: fin_en    = 1'b1;
      default:   busy      = 1'b1;
    endcase
    accept          = start && !busy;
    scan_ctrl.clear = accept && (in_op == OP_ACQUIRE);
    scan_ctrl.step  = cmp_vld_r;
    rel_en          = accept && (in_op == OP_RELEASE);
  end

  // Decide the acquire outcome and the release target
  always_comb begin
    fin_hit   = scan_flags.hit;
    fin_miss  = !scan_flags.hit && scan_flags.victim;
    fin_apply = fin_en && (fin_hit || fin_miss);
    fin_slot  = fin_hit ? hit_idx : vict_idx;
    fin_rank  = fin_hit ? hit_rank : vict_rank;
    fin_wb    = fin_miss && valid_r[vict_idx] && dirty_r[vict_idx];
    rel_ok    = (int'(in_slot) < NUM_BUFFERS);
    rel_idx   = IDX_W'(in_slot);
  end

  // Advance the sequencer and walk the entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= ram_rd_en;
      if (scan_ctrl.clear) begin
        idx_r <= '0;
      end else if (ram_rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Hold the lookup key and the index in compare
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (scan_ctrl.clear) begin
      key_r <= in_block_number;
    end
  end

  // Update per-entry flags and recency ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      pinned_r <= '0;
      dirty_r  <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else begin
      if (rel_en && rel_ok) begin
        pinned_r[rel_idx] <= 1'b0;
        if (in_modified && valid_r[rel_idx]) begin
          dirty_r[rel_idx] <= 1'b1;
        end
      end
      if (fin_apply) begin
        pinned_r[fin_slot] <= 1'b1;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if (IDX_W'(i) == fin_slot) begin
            rank_r[i] <= '0;
          end else if (rank_r[i] < fin_rank) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
      if (fin_en && fin_miss) begin
        valid_r[vict_idx] <= 1'b1;
        dirty_r[vict_idx] <= 1'b0;
      end
    end
  end

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rel_en || fin_en;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (rel_en) begin
      out_status_r    <= STATUS_RELEASED;
      out_slot_r      <= in_slot;
      out_fetch_r     <= '0;
      out_wb_needed_r <= 1'b0;
      out_wb_block_r  <= '0;
    end else if (fin_en) begin
      if (fin_hit) begin
        out_status_r <= STATUS_HIT;
        out_slot_r   <= SLOT_W'(fin_slot);
        out_fetch_r  <= '0;
      end else if (fin_miss) begin
        out_status_r <= STATUS_MISS;
        out_slot_r   <= SLOT_W'(fin_slot);
        out_fetch_r  <= key_r;
      end else begin
        out_status_r <= STATUS_DEADLOCK;
        out_slot_r   <= '0;
        out_fetch_r  <= '0;
      end
      out_wb_needed_r <= fin_wb;
      out_wb_block_r  <= fin_wb ? vict_tag : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slot_out         = out_slot_r;
  assign out_fetch_block      = out_fetch_r;
  assign out_writeback_needed = out_wb_needed_r;
  assign out_writeback_block  = out_wb_block_r;

`ifndef ASSERT_OFF
  // A result follows an accepted release or the end of a walk
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rel_en) || $past(fin_en))
    else $error("result without a finished operation");

  // Deadlock is reported only when every entry is pinned
  a_deadlock_pinned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_DEADLOCK)) |-> (&pinned_r))
    else $error("deadlock reported with an unpinned entry");

  // Writeback is reported only on a miss
  a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_writeback_needed) |-> (out_status == STATUS_MISS))
    else $error("writeback outside a miss");

  // The walk ends in the final step after the last entry was read
  a_walk_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> ($past(idx_r) == LAST_IDX) && cmp_vld_r)
    else $error("walk ended early");
`endif

endmodule

// File: sv/lbc_tag_ram.sv
module lbc_tag_ram import lbc_pkg::*; #(
  parameter int DEPTH  = NUM_BUFFERS_DEF,
  parameter int ADDR_W = $clog2(NUM_BUFFERS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BLK_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BLK_W-1:0]  rd_data
);

  logic [BLK_W-1:0] mem [DEPTH];
  logic [BLK_W-1:0] rd_data_r;

  // Write one tag per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one tag per cycle, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/lbc_scan.sv
module lbc_scan import lbc_pkg::*; #(
  parameter int IDX_W = $clog2(NUM_BUFFERS_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] ent_idx,
  input  logic             ent_valid,
  input  logic             ent_pinned,
  input  logic [IDX_W-1:0] ent_rank,
  input  logic [BLK_W-1:0] ent_tag,
  input  logic [BLK_W-1:0] key,
  output scan_flags_t      flags,
  output logic [IDX_W-1:0] hit_idx,
  output logic [IDX_W-1:0] hit_rank,
  output logic [IDX_W-1:0] vict_idx,
  output logic [IDX_W-1:0] vict_rank,
  output logic [BLK_W-1:0] vict_tag
);

  logic             hit_found_r;
  logic             vict_found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] hit_rank_r;
  logic [IDX_W-1:0] vict_idx_r;
  logic [IDX_W-1:0] vict_rank_r;
  logic [BLK_W-1:0] vict_tag_r;
  logic             take_hit;
  logic             take_vict;

  // Compare one entry: newest matching tag, oldest unpinned entry
  always_comb begin
    take_hit  = ctrl.step && ent_valid && (ent_tag == key) &&
                (!hit_found_r || (ent_rank < hit_rank_r));
    take_vict = ctrl.step && !ent_pinned &&
                (!vict_found_r || (ent_rank > vict_rank_r));
  end

  // Track found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      vict_found_r <= 1'b0;
    end else if (ctrl.clear) begin
      hit_found_r  <= 1'b0;
      vict_found_r <= 1'b0;
    end else begin
      if (take_hit) begin
        hit_found_r <= 1'b1;
      end
      if (take_vict) begin
        vict_found_r <= 1'b1;
      end
    end
  end

  // Hold best candidates
  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx_r  <= ent_idx;
      hit_rank_r <= ent_rank;
    end
    if (take_vict) begin
      vict_idx_r  <= ent_idx;
      vict_rank_r <= ent_rank;
      vict_tag_r  <= ent_tag;
    end
  end

  assign flags.hit    = hit_found_r;
  assign flags.victim = vict_found_r;
  assign hit_idx      = hit_idx_r;
  assign hit_rank     = hit_rank_r;
  assign vict_idx     = vict_idx_r;
  assign vict_rank    = vict_rank_r;
  assign vict_tag     = vict_tag_r;

endmodule
